@@ rtl/core/sed_pkg.sv @@
// Package for the string escape decoder: decoder modes and character codes.
// No dependencies; used by string_escape_decoder.
`default_nettype none

package sed_pkg;

  // Decoder mode for the byte stream.
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2,
    MODE_SKIP  = 2'd3
  } mode_t;

  // Character codes.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_UPPER_U = 8'h55;

  // Number of hex digits for the short and long unicode escapes.
  localparam logic [3:0] HEX_SHORT = 4'd4;
  localparam logic [3:0] HEX_LONG  = 4'd8;

  // UTF-8 lead and continuation marks.
  localparam logic [7:0] UTF_CONT  = 8'h80;
  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;

  // Hex digit check and value.
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/string_escape_decoder.sv @@
// Top level of the string escape decoder: input register, escape decode,
// result bundle register and byte serializer. Depends on sed_pkg.
`default_nettype none

// The decoder takes the body of a basic quoted string one byte per
// transaction and returns the decoded bytes one per output transaction.
// An accepted byte is held in the input register, is decoded in a single
// pass into a bundle of up to four result bytes, and the bundle is sent out
// one result per cycle while out_stall is low; the bundle register sits
// behind the input register. A byte that yields k results holds the output
// port until all k are taken, so the block takes one byte per cycle while
// out_stall is low and each byte yields at most one result; behind a byte
// with more, the bundle register and its serializer hold the next byte.
// A byte that yields nothing gives no result, except the last byte of a
// string, which gives at least one, the last with string_end set.
module string_escape_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] raw_byte,
  input  wire logic       string_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            run_last,
  output logic            string_end,
  output logic            bad_escape
);

  // Input register.
  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_last;

  // Decoder state.
  sed_pkg::mode_t mode, mode_next;
  logic [3:0]     left, left_next;
  logic [31:0]    acc, acc_next;
  logic           err, err_next;

  // Result bundle register.
  logic            bv;
  logic [3:0][7:0] bbytes;
  logic [1:0]      bcnt;
  logic [1:0]      bidx;
  logic            bhas;
  logic            bend;
  logic            berr;

  // Decode results for the byte in the input register.
  logic [3:0][7:0] emit;
  logic [2:0]      emit_n;
  sed_pkg::hex_t   hex;
  logic [31:0]     acc_shift;
  logic [3:0]      left_dec;

  logic take, take_final, bundle_free, advance, produce;

  assign take        = out_valid && !out_stall;
  assign take_final  = take && (bidx == bcnt);
  assign bundle_free = !bv || take_final;
  assign advance     = ir_valid && bundle_free;
  assign in_stall    = ir_valid && !advance;
  assign produce     = advance && (emit_n != 3'd0 || ir_last);

  assign hex       = sed_pkg::hex_decode(ir_byte);
  assign acc_shift = {acc[27:0], hex.value};
  assign left_dec  = left - 4'd1;

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      ir_byte <= raw_byte;
      ir_last <= string_last;
    end
  end

  // Next decoder state.
  always_comb begin
    mode_next = mode;
    left_next = left;
    acc_next  = acc;
    err_next  = err;
    if (!err) begin
      case (mode)
        sed_pkg::MODE_ESC: begin
          mode_next = sed_pkg::MODE_PLAIN;
          if (ir_byte == sed_pkg::CH_LF) begin
            mode_next = sed_pkg::MODE_SKIP;
          end else if (ir_byte == sed_pkg::CH_LOWER_U ||
                       ir_byte == sed_pkg::CH_UPPER_U) begin
            mode_next = sed_pkg::MODE_HEX;
            left_next = (ir_byte == sed_pkg::CH_LOWER_U) ?
                        sed_pkg::HEX_SHORT : sed_pkg::HEX_LONG;
            acc_next  = 32'd0;
            if (ir_last) begin
              err_next = 1'b1;
            end
          end
        end
        sed_pkg::MODE_HEX: begin
          if (!hex.ok) begin
            err_next  = 1'b1;
            mode_next = sed_pkg::MODE_PLAIN;
          end else begin
            acc_next  = acc_shift;
            left_next = left_dec;
            if (left_dec == 4'd0) begin
              mode_next = sed_pkg::MODE_PLAIN;
            end else if (ir_last) begin
              err_next = 1'b1;
            end
          end
        end
        sed_pkg::MODE_SKIP: begin
          if (!(ir_byte == sed_pkg::CH_SPACE || ir_byte == sed_pkg::CH_TAB ||
                ir_byte == sed_pkg::CH_LF || ir_byte == sed_pkg::CH_CR)) begin
            mode_next = (ir_byte == sed_pkg::CH_BSLASH && !ir_last) ?
                        sed_pkg::MODE_ESC : sed_pkg::MODE_PLAIN;
          end
        end
        default: begin
          mode_next = (ir_byte == sed_pkg::CH_BSLASH && !ir_last) ?
                      sed_pkg::MODE_ESC : sed_pkg::MODE_PLAIN;
        end
      endcase
    end
  end

  // Bytes emitted for the byte in the input register.
  always_comb begin
    emit   = '0;
    emit_n = 3'd0;
    if (!err) begin
      case (mode)
        sed_pkg::MODE_ESC: begin
          emit_n = 3'd1;
          case (ir_byte)
            sed_pkg::CH_N:       emit[0] = sed_pkg::CH_LF;
            sed_pkg::CH_T:       emit[0] = sed_pkg::CH_TAB;
            sed_pkg::CH_R:       emit[0] = sed_pkg::CH_CR;
            sed_pkg::CH_B:       emit[0] = sed_pkg::CH_BS;
            sed_pkg::CH_F:       emit[0] = sed_pkg::CH_FF;
            sed_pkg::CH_LF,
            sed_pkg::CH_LOWER_U,
            sed_pkg::CH_UPPER_U: emit_n  = 3'd0;
            default:             emit[0] = ir_byte;
          endcase
        end
        sed_pkg::MODE_HEX: begin
          // Last hex digit completes the code point; encode it as UTF-8.
          if (hex.ok && left_dec == 4'd0) begin
            if (acc_shift[31:7] == 25'd0) begin
              emit_n  = 3'd1;
              emit[0] = acc_shift[7:0];
            end else if (acc_shift[31:11] == 21'd0) begin
              emit_n  = 3'd2;
              emit[0] = sed_pkg::UTF_LEAD2 | {3'd0, acc_shift[10:6]};
              emit[1] = sed_pkg::UTF_CONT | {2'd0, acc_shift[5:0]};
            end else if (acc_shift[31:16] == 16'd0) begin
              emit_n  = 3'd3;
              emit[0] = sed_pkg::UTF_LEAD3 | {4'd0, acc_shift[15:12]};
              emit[1] = sed_pkg::UTF_CONT | {2'd0, acc_shift[11:6]};
              emit[2] = sed_pkg::UTF_CONT | {2'd0, acc_shift[5:0]};
            end else begin
              emit_n  = 3'd4;
              emit[0] = sed_pkg::UTF_LEAD4 | acc_shift[25:18];
              emit[1] = sed_pkg::UTF_CONT | {2'd0, acc_shift[17:12]};
              emit[2] = sed_pkg::UTF_CONT | {2'd0, acc_shift[11:6]};
              emit[3] = sed_pkg::UTF_CONT | {2'd0, acc_shift[5:0]};
            end
          end
        end
        sed_pkg::MODE_SKIP: begin
          if (!(ir_byte == sed_pkg::CH_SPACE || ir_byte == sed_pkg::CH_TAB ||
                ir_byte == sed_pkg::CH_LF || ir_byte == sed_pkg::CH_CR) &&
              !(ir_byte == sed_pkg::CH_BSLASH && !ir_last)) begin
            emit_n  = 3'd1;
            emit[0] = ir_byte;
          end
        end
        default: begin
          if (!(ir_byte == sed_pkg::CH_BSLASH && !ir_last)) begin
            emit_n  = 3'd1;
            emit[0] = ir_byte;
          end
        end
      endcase
    end
  end

  // Decoder state update; the end of a string returns it to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sed_pkg::MODE_PLAIN;
      left <= 4'd0;
      acc  <= 32'd0;
      err  <= 1'b0;
    end else if (advance) begin
      if (ir_last) begin
        mode <= sed_pkg::MODE_PLAIN;
        left <= 4'd0;
        acc  <= 32'd0;
        err  <= 1'b0;
      end else begin
        mode <= mode_next;
        left <= left_next;
        acc  <= acc_next;
        err  <= err_next;
      end
    end
  end

  // Bundle register and serializer index.
  always_ff @(posedge clk) begin
    if (rst) begin
      bv   <= 1'b0;
      bidx <= 2'd0;
    end else if (produce) begin
      bv   <= 1'b1;
      bidx <= 2'd0;
    end else if (take_final) begin
      bv   <= 1'b0;
    end else if (take) begin
      bidx <= bidx + 2'd1;
    end
    if (produce) begin
      bbytes <= emit;
      bcnt   <= (emit_n == 3'd0) ? 2'd0 : 2'(emit_n - 3'd1);
      bhas   <= (emit_n != 3'd0);
      bend   <= ir_last;
      berr   <= err_next;
    end
  end

  // Output fields of the current result.
  assign out_valid  = bv;
  assign byte_valid = bhas;
  assign out_byte   = bhas ? bbytes[bidx] : 8'd0;
  assign run_last   = (bidx == bcnt);
  assign string_end = bend && run_last;
  assign bad_escape = berr && bend && run_last;

endmodule

`default_nettype wire
